@@ rtl/crf_pkg.sv @@
// ----------------------------------------------------------------------------
// crf_pkg: shared types and constants for the client registry forwarder
// Field widths, request and response codes, sequencer states and the
// table control bundle used between the sequencer and the table.
// ----------------------------------------------------------------------------
package crf_pkg;

   // field widths
   localparam int MODE_W = 2;
   localparam int ID_W   = 22;
   localparam int REF_W  = 16;
   localparam int SLOT_W = 5;
   localparam int KIND_W = 3;

   // table sizing
   localparam int TABLE_ENTRIES_DEF = 32;
   localparam int MAX_RESULTS       = 32;

   // request modes
   typedef enum logic [MODE_W-1:0] {
      MODE_BROADCAST  = 2'd0,
      MODE_REGISTER   = 2'd1,
      MODE_DISCONNECT = 2'd2,
      MODE_UNICAST    = 2'd3
   } mode_type;

   // response kinds
   typedef enum logic [KIND_W-1:0] {
      K_DELIVER       = 3'd0,
      K_REGISTERED    = 3'd1,
      K_ALREADY       = 3'd2,
      K_FULL          = 3'd3,
      K_DISCONNECTED  = 3'd4,
      K_NOT_REG       = 3'd5,
      K_NO_RECEIVER   = 3'd6,
      K_NO_RECIPIENTS = 3'd7
   } kind_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_SCAN   = 2'd1,
      ST_DRAIN  = 2'd2,
      ST_FINISH = 2'd3
   } state_type;

   // table write and clear controls
   typedef struct packed {
      logic            wr_en;
      logic            clr_en;
      logic [ID_W-1:0] wr_client;
   } tbl_ctrl_type;

endpackage

@@ rtl/client_registry_forwarder.sv @@
// ----------------------------------------------------------------------------
// client_registry_forwarder: client registry with unicast and broadcast
// Keeps a table of registered client ids and turns each request into
// status or delivery transactions by scanning the table with one comparator.
// ----------------------------------------------------------------------------
// Usage:
//   A request transaction is taken on a rising edge with start high and busy
//   low; req_mode selects broadcast, register, disconnect or unicast.
//   Results leave on the rsp_ ports, each valid for one cycle under
//   rsp_strobe; the receiver cannot stall, so no result is ever held back.
//   rsp_last marks the final result of a request.
// Timing:
//   Every request walks the whole table through one registered read port,
//   one slot per cycle, with one id comparator checking a slot per cycle.
//   busy stays high from the accept through the scan, drain and finish
//   steps; the next request can be taken at the end of the first cycle
//   busy is low, so a new request is never taken before the last is done.
//   Each broadcast delivery is held in the pending register until the next
//   recipient is found, then leaves through the response registers; the
//   final result is on the ports in the first cycle busy is low.
// Reset:
//   Synchronous, active high; all slots become free and the block idles.
//   No clearing pass is needed.
// ----------------------------------------------------------------------------
module client_registry_forwarder
   import crf_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [MODE_W-1:0] req_mode,
   input  logic [ID_W-1:0]   req_sender_id,
   input  logic [ID_W-1:0]   req_receiver_id,
   input  logic [REF_W-1:0]  req_message_ref,
   output logic              rsp_strobe,
   output logic [KIND_W-1:0] rsp_kind,
   output logic [ID_W-1:0]   rsp_dest_id,
   output logic [SLOT_W-1:0] rsp_slot,
   output logic [REF_W-1:0]  rsp_message_out,
   output logic              rsp_last
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int CNT_W = $clog2(MAX_RESULTS + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
   localparam logic [CNT_W-1:0] CNT_CAP  = CNT_W'(MAX_RESULTS);

   // sequencer and request registers
   state_type        state_ff,     state_in;
   logic [IDX_W-1:0] idx_ff,       idx_in;
   logic             chk_vld_ff,   chk_vld_in;
   logic [IDX_W-1:0] chk_idx_ff,   chk_idx_in;
   mode_type         mode_ff,      mode_in;
   logic [ID_W-1:0]  snd_ff,       snd_in;
   logic [ID_W-1:0]  rcv_ff,       rcv_in;
   logic [REF_W-1:0] ref_ff,       ref_in;

   // scan results
   logic             hit_ff,       hit_in;
   logic [IDX_W-1:0] hit_slot_ff,  hit_slot_in;
   logic             free_ff,      free_in;
   logic [IDX_W-1:0] free_slot_ff, free_slot_in;
   logic             pend_ff,      pend_in;
   logic [ID_W-1:0]  pend_dest_ff, pend_dest_in;
   logic [IDX_W-1:0] pend_slot_ff, pend_slot_in;
   logic [CNT_W-1:0] cnt_ff,       cnt_in;

   // response registers
   logic              rsp_strobe_ff, rsp_strobe_in;
   kind_type          rsp_kind_ff,   rsp_kind_in;
   logic [ID_W-1:0]   rsp_dest_ff,   rsp_dest_in;
   logic [SLOT_W-1:0] rsp_slot_ff,   rsp_slot_in;
   logic [REF_W-1:0]  rsp_ref_ff,    rsp_ref_in;
   logic              rsp_last_ff,   rsp_last_in;

   // table interface
   tbl_ctrl_type     tbl_ctrl;
   logic [IDX_W-1:0] tbl_wr_addr;
   logic [IDX_W-1:0] tbl_clr_addr;
   logic [ID_W-1:0]  tbl_rd_client;
   logic             tbl_rd_valid;

   // shared comparator
   logic [ID_W-1:0]  key;
   logic             id_match;

   crf_table #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_table (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (tbl_ctrl),
      .wr_addr   (tbl_wr_addr),
      .clr_addr  (tbl_clr_addr),
      .rd_addr   (idx_ff),
      .rd_client (tbl_rd_client),
      .rd_valid  (tbl_rd_valid)
   );

   assign key      = (mode_ff == MODE_UNICAST) ? rcv_ff : snd_ff;
   assign id_match = (tbl_rd_client == key);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         chk_vld_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         chk_vld_ff    <= chk_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      chk_idx_ff   <= chk_idx_in;
      mode_ff      <= mode_in;
      snd_ff       <= snd_in;
      rcv_ff       <= rcv_in;
      ref_ff       <= ref_in;
      hit_ff       <= hit_in;
      hit_slot_ff  <= hit_slot_in;
      free_ff      <= free_in;
      free_slot_ff <= free_slot_in;
      pend_ff      <= pend_in;
      pend_dest_ff <= pend_dest_in;
      pend_slot_ff <= pend_slot_in;
      cnt_ff       <= cnt_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_dest_ff  <= rsp_dest_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_ref_ff   <= rsp_ref_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // sequencer, check stage and result forming
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      chk_vld_in    = (state_ff == ST_SCAN);
      chk_idx_in    = idx_ff;
      mode_in       = mode_ff;
      snd_in        = snd_ff;
      rcv_in        = rcv_ff;
      ref_in        = ref_ff;
      hit_in        = hit_ff;
      hit_slot_in   = hit_slot_ff;
      free_in       = free_ff;
      free_slot_in  = free_slot_ff;
      pend_in       = pend_ff;
      pend_dest_in  = pend_dest_ff;
      pend_slot_in  = pend_slot_ff;
      cnt_in        = cnt_ff;
      rsp_strobe_in = 1'b0;
      rsp_kind_in   = rsp_kind_ff;
      rsp_dest_in   = rsp_dest_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_ref_in    = rsp_ref_ff;
      rsp_last_in   = rsp_last_ff;
      tbl_ctrl      = '0;
      tbl_ctrl.wr_client = snd_ff;
      tbl_wr_addr   = free_slot_ff;
      tbl_clr_addr  = chk_idx_ff;

      // check one slot per cycle as its read data arrives
      if (chk_vld_ff) begin
         case (mode_ff)
            MODE_REGISTER: begin
               if (tbl_rd_valid && id_match && !hit_ff) begin
                  hit_in      = 1'b1;
                  hit_slot_in = chk_idx_ff;
               end
               if (!tbl_rd_valid && !free_ff) begin
                  free_in      = 1'b1;
                  free_slot_in = chk_idx_ff;
               end
            end
            MODE_DISCONNECT: begin
               if (tbl_rd_valid && id_match) begin
                  tbl_ctrl.clr_en = 1'b1;
                  if (!hit_ff) begin
                     hit_in      = 1'b1;
                     hit_slot_in = chk_idx_ff;
                  end
               end
            end
            MODE_UNICAST: begin
               if (tbl_rd_valid && id_match && !hit_ff) begin
                  hit_in      = 1'b1;
                  hit_slot_in = chk_idx_ff;
               end
            end
            MODE_BROADCAST: begin
               // hold one delivery back so the final one can carry last
               if (tbl_rd_valid && !id_match && (cnt_ff < CNT_CAP)) begin
                  if (pend_ff) begin
                     rsp_strobe_in = 1'b1;
                     rsp_kind_in   = K_DELIVER;
                     rsp_dest_in   = pend_dest_ff;
                     rsp_slot_in   = SLOT_W'(pend_slot_ff);
                     rsp_ref_in    = ref_ff;
                     rsp_last_in   = 1'b0;
                  end
                  pend_in      = 1'b1;
                  pend_dest_in = tbl_rd_client;
                  pend_slot_in = chk_idx_ff;
                  cnt_in       = cnt_ff + CNT_W'(1);
               end
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               mode_in  = mode_type'(req_mode);
               snd_in   = req_sender_id;
               rcv_in   = req_receiver_id;
               ref_in   = req_message_ref;
               idx_in   = '0;
               hit_in   = 1'b0;
               free_in  = 1'b0;
               pend_in  = 1'b0;
               cnt_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            idx_in = idx_ff + IDX_W'(1);
            if (idx_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // final transaction of the request
            state_in      = ST_IDLE;
            rsp_strobe_in = 1'b1;
            rsp_ref_in    = ref_ff;
            rsp_last_in   = 1'b1;
            rsp_dest_in   = snd_ff;
            rsp_slot_in   = '0;
            case (mode_ff)
               MODE_REGISTER: begin
                  if (hit_ff) begin
                     rsp_kind_in = K_ALREADY;
                     rsp_slot_in = SLOT_W'(hit_slot_ff);
                  end else if (free_ff) begin
                     tbl_ctrl.wr_en = 1'b1;
                     rsp_kind_in    = K_REGISTERED;
                     rsp_slot_in    = SLOT_W'(free_slot_ff);
                  end else begin
                     rsp_kind_in = K_FULL;
                  end
               end
               MODE_DISCONNECT: begin
                  if (hit_ff) begin
                     rsp_kind_in = K_DISCONNECTED;
                     rsp_slot_in = SLOT_W'(hit_slot_ff);
                  end else begin
                     rsp_kind_in = K_NOT_REG;
                  end
               end
               MODE_UNICAST: begin
                  if (hit_ff) begin
                     rsp_kind_in = K_DELIVER;
                     rsp_dest_in = rcv_ff;
                     rsp_slot_in = SLOT_W'(hit_slot_ff);
                  end else begin
                     rsp_kind_in = K_NO_RECEIVER;
                  end
               end
               MODE_BROADCAST: begin
                  if (pend_ff) begin
                     rsp_kind_in = K_DELIVER;
                     rsp_dest_in = pend_dest_ff;
                     rsp_slot_in = SLOT_W'(pend_slot_ff);
                  end else begin
                     rsp_kind_in = K_NO_RECIPIENTS;
                  end
               end
               default: begin
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_dest_id     = rsp_dest_ff;
   assign rsp_slot        = rsp_slot_ff;
   assign rsp_message_out = rsp_ref_ff;
   assign rsp_last        = rsp_last_ff;

`ifndef SYNTHESIS
   // an accepted request keeps the block busy on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   // a final transaction comes only right after the finish step
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last) |-> $past(state_ff == ST_FINISH))
      else $error("final transaction outside the finish step");

   // status transactions are always the only and final one
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_kind != K_DELIVER)) |-> rsp_last)
      else $error("status transaction without last");

   // no transaction while idle unless it is the final one just formed
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !busy) |-> (rsp_last && $past(state_ff == ST_FINISH)))
      else $error("transaction while idle");
`endif

endmodule

@@ rtl/crf_table.sv @@
// ----------------------------------------------------------------------------
// crf_table: client id table with per-slot valid bits
// One registered read port for id and valid, one write port that fills a
// slot and marks it valid, and one clear port that drops a valid bit.
// ----------------------------------------------------------------------------
module crf_table
   import crf_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  tbl_ctrl_type                     ctrl,
   input  logic [$clog2(TABLE_ENTRIES)-1:0] wr_addr,
   input  logic [$clog2(TABLE_ENTRIES)-1:0] clr_addr,
   input  logic [$clog2(TABLE_ENTRIES)-1:0] rd_addr,
   output logic [ID_W-1:0]                  rd_client,
   output logic                             rd_valid
);

   logic [ID_W-1:0]          client_mem_ff [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] valid_ff;
   logic [ID_W-1:0]          rd_client_ff;
   logic                     rd_valid_ff;

   // id storage, registered read
   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         client_mem_ff[wr_addr] <= ctrl.wr_client;
      end
      rd_client_ff <= client_mem_ff[rd_addr];
   end

   // valid bits, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (ctrl.wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (ctrl.clr_en) begin
            valid_ff[clr_addr] <= 1'b0;
         end
      end
   end

   // registered valid read alongside the id
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_client = rd_client_ff;
   assign rd_valid  = rd_valid_ff;

endmodule
